// ===== design/qcb_pkg.sv =====
// Shared constants, register codes and angle tables for the quadrilateral check.
// No dependencies; qcb_front, qcb_cordic_stage, qcb_check and the top level import it.
`default_nettype none
package qcb_pkg;

	localparam int COORD_BITS_DEF      = 11;
	localparam int ANGLE_FRAC_BITS_DEF = 6;

	localparam int INT_FRAC     = 20;  // internal angle unit is 2^-20 degree
	localparam int PRESCALE     = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int ANG_W        = 28;  // unsigned angle, up to a half turn
	localparam int Z_W          = 29;  // signed CORDIC angle accumulator
	localparam int OUT_W        = 14;

	localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(188757583);
	localparam logic [ANG_W-1:0] STRAIGHT  = ANG_W'(180 << INT_FRAC);

	localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		ANG_W'(47189396), ANG_W'(27857527), ANG_W'(14719152), ANG_W'(7471671),
		ANG_W'(3750335),  ANG_W'(1876996),  ANG_W'(938727),   ANG_W'(469392),
		ANG_W'(234700),   ANG_W'(117350),   ANG_W'(58675),    ANG_W'(29338),
		ANG_W'(14669),    ANG_W'(7334),     ANG_W'(3667),     ANG_W'(1834),
		ANG_W'(917),      ANG_W'(458),      ANG_W'(229),      ANG_W'(115),
		ANG_W'(57),       ANG_W'(29),       ANG_W'(14),       ANG_W'(7)
	};

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_TOL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORNER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORNER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_RATIO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE   = 3'd4;

	localparam logic [6:0]  RST_CORNER_TOL = 7'd15;
	localparam logic [7:0]  RST_MAX_CORNER = 8'd145;
	localparam logic [7:0]  RST_MIN_CORNER = 8'd35;
	localparam logic [4:0]  RST_SIDE_RATIO = 5'd4;
	localparam logic [10:0] RST_MIN_SIDE   = 11'd10;

	typedef struct packed {
		logic [6:0] corner_tol;
		logic [7:0] max_corner;
		logic [7:0] min_corner;
	} angle_cfg_t;

endpackage
`default_nettype wire

// ===== design/qcb_quad_if.sv =====
// Input channel: the four corners of one quadrilateral per beat.
// Standalone interface, no package use.
`default_nettype none
interface qcb_quad_if #(parameter int COORD_BITS = 11);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] corner0_x;
	logic [COORD_BITS-1:0] corner0_y;
	logic [COORD_BITS-1:0] corner1_x;
	logic [COORD_BITS-1:0] corner1_y;
	logic [COORD_BITS-1:0] corner2_x;
	logic [COORD_BITS-1:0] corner2_y;
	logic [COORD_BITS-1:0] corner3_x;
	logic [COORD_BITS-1:0] corner3_y;

	modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
		corner2_x, corner2_y, corner3_x, corner3_y, input ready);
	modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
		corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface
`default_nettype wire

// ===== design/qcb_result_if.sv =====
// Output channel: verdict and least edge angle, one beat per quadrilateral.
// Standalone interface, no package use.
`default_nettype none
interface qcb_result_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [13:0] min_edge_angle;

	modport source (output valid, accepted, min_edge_angle, input ready);
	modport sink (input valid, accepted, min_edge_angle, output ready);
endinterface
`default_nettype wire

// ===== design/qcb_front.sv =====
// Front end: edge vectors, dot/cross products, squared sides, side checks and
// CORDIC operand setup, four register stages. Uses qcb_pkg.
`default_nettype none
module qcb_front #(
	parameter int COORD_BITS = 11,
	parameter int PRESCALE_W = qcb_pkg::PRESCALE + 4
) (
	input  wire logic                  clk,
	input  wire logic                  adv,
	input  wire logic [COORD_BITS-1:0] px [4],
	input  wire logic [COORD_BITS-1:0] py [4],
	input  wire logic [9:0]            r2,
	input  wire logic [21:0]           ms2,
	output logic signed [2*COORD_BITS+PRESCALE_W-1:0] x0 [8],
	output logic signed [2*COORD_BITS+PRESCALE_W-1:0] y0 [8],
	output logic                       neg0 [8],
	output logic                       zero0 [8],
	output logic                       side_ok
);
	import qcb_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int M = 2 * COORD_BITS + 1;
	localparam int W = 2 * COORD_BITS + PRESCALE_W;

	logic signed [D-1:0]   ex_s1 [4], ey_s1 [4];
	logic signed [D-1:0]   ex_s2 [4], ey_s2 [4];
	logic signed [2*D-1:0] pxx_s2 [4], pyy_s2 [4], pxy_s2 [4], pyx_s2 [4];
	logic signed [2*D-1:0] sx2_s2 [4], sy2_s2 [4];
	logic signed [D-1:0]   ex_s3 [4], ey_s3 [4];
	logic signed [2*D:0]   dot_s3 [4];
	logic [M-1:0]          cr_s3 [4], d2_s3 [4];

	logic signed [2*D:0] dsum [4], cdif [4], cabs [4], dsq [4], dmag [4];
	logic [D-1:0]        emag [4], exab [4];
	logic [M+9:0]        pa [4], pb [4];
	logic                sok;

	always_comb begin
		sok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			dsum[i] = -(pxx_s2[i] + pyy_s2[i]);
			cdif[i] = pyx_s2[i] - pxy_s2[i];
			cabs[i] = cdif[i][2*D] ? -cdif[i] : cdif[i];
			dsq[i]  = sx2_s2[i] + sy2_s2[i];
			dmag[i] = dot_s3[i][2*D] ? -dot_s3[i] : dot_s3[i];
			emag[i] = ey_s3[i][D-1] ? D'(-ey_s3[i]) : D'(ey_s3[i]);
			exab[i] = ex_s3[i][D-1] ? D'(-ex_s3[i]) : D'(ex_s3[i]);
			pa[i]   = r2 * d2_s3[(i+1)%4];
			pb[i]   = r2 * d2_s3[i];
			if (d2_s3[i] == '0 || (M+10)'(d2_s3[i]) > pa[i] ||
				pb[i] < (M+10)'(d2_s3[(i+1)%4]) || (M+22)'(d2_s3[i]) < (M+22)'(ms2))
				sok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				// S1: edge vector Pi -> P(i+1)
				ex_s1[i] <= signed'({1'b0, px[(i+1)%4]}) - signed'({1'b0, px[i]});
				ey_s1[i] <= signed'({1'b0, py[(i+1)%4]}) - signed'({1'b0, py[i]});
				// S2: products against the previous edge
				ex_s2[i]  <= ex_s1[i];
				ey_s2[i]  <= ey_s1[i];
				pxx_s2[i] <= ex_s1[i] * ex_s1[(i+3)%4];
				pyy_s2[i] <= ey_s1[i] * ey_s1[(i+3)%4];
				pxy_s2[i] <= ex_s1[i] * ey_s1[(i+3)%4];
				pyx_s2[i] <= ey_s1[i] * ex_s1[(i+3)%4];
				sx2_s2[i] <= ex_s1[i] * ex_s1[i];
				sy2_s2[i] <= ey_s1[i] * ey_s1[i];
				// S3: corner vectors are e_i and -e_(i-1)
				ex_s3[i]  <= ex_s2[i];
				ey_s3[i]  <= ey_s2[i];
				dot_s3[i] <= dsum[i];
				cr_s3[i]  <= cabs[i][M-1:0];
				d2_s3[i]  <= dsq[i][M-1:0];
				// S4: interior corner operands (x = dot, y = |cross|)
				neg0[i]  <= dot_s3[i][2*D];
				zero0[i] <= (dot_s3[i] == '0) && (cr_s3[i] == '0);
				x0[i]    <= signed'(W'(dmag[i][M-1:0]) << PRESCALE);
				y0[i]    <= signed'(W'(cr_s3[i]) << PRESCALE);
				// S4: edge direction operands (x = -dy, y = |dx|)
				neg0[4+i]  <= !ey_s3[i][D-1] && (ey_s3[i] != '0);
				zero0[4+i] <= (ex_s3[i] == '0) && (ey_s3[i] == '0);
				x0[4+i]    <= signed'(W'(emag[i]) << PRESCALE);
				y0[4+i]    <= signed'(W'(exab[i]) << PRESCALE);
			end
			side_ok <= sok;
		end
	end

endmodule
`default_nettype wire

// ===== design/qcb_cordic_stage.sv =====
// One vectoring CORDIC micro-rotation with its output register.
// Uses the arctangent table of qcb_pkg.
`default_nettype none
module qcb_cordic_stage #(
	parameter int W = 42,
	parameter int K = 0
) (
	input  wire logic                    clk,
	input  wire logic                    adv,
	input  wire logic signed [W-1:0]     x_in,
	input  wire logic signed [W-1:0]     y_in,
	input  wire logic signed [qcb_pkg::Z_W-1:0] z_in,
	input  wire logic                    neg_in,
	input  wire logic                    zero_in,
	output logic signed [W-1:0]          x_out,
	output logic signed [W-1:0]          y_out,
	output logic signed [qcb_pkg::Z_W-1:0] z_out,
	output logic                         neg_out,
	output logic                         zero_out
);
	import qcb_pkg::*;

	localparam logic signed [Z_W-1:0] STEP = signed'(Z_W'(ATAN_TAB[K]));

	logic signed [W-1:0] xs, ys;

	// arithmetic shift floors negative values
	assign xs = x_in >>> K;
	assign ys = y_in >>> K;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!y_in[W-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + STEP;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - STEP;
			end
			neg_out  <= neg_in;
			zero_out <= zero_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/qcb_check.sv =====
// Back end: angle recovery, corner and pair checks, edge minimum and output
// rounding, three register stages. Uses qcb_pkg.
`default_nettype none
module qcb_check #(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  wire logic                           clk,
	input  wire logic                           adv,
	input  wire logic signed [qcb_pkg::Z_W-1:0] z [8],
	input  wire logic                           neg [8],
	input  wire logic                           zero [8],
	input  wire logic                           side_ok,
	input  wire qcb_pkg::angle_cfg_t            acfg,
	output logic                                accepted,
	output logic [qcb_pkg::OUT_W-1:0]           min_edge_angle
);
	import qcb_pkg::*;

	localparam int SH = INT_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ANG_W:0] HALF = (ANG_W+1)'(1) << (SH - 1);

	logic [ANG_W-1:0] ang_s1 [8];
	logic             nz_s1 [4];
	logic             side_ok_s1;
	logic             ok_s2;
	logic [ANG_W-1:0] m01_s2, m23_s2;

	logic [ANG_W-1:0]        q [8], aq [8], cand [4], m01, m23, emin;
	logic signed [ANG_W+1:0] s [4];
	logic [ANG_W+1:0]        sa [4];
	logic                    aok;
	logic [ANG_W:0]          rnd, shv;

	always_comb begin
		for (int u = 0; u < 8; u++) begin
			q[u]  = (zero[u] || z[u][Z_W-1]) ? '0 : z[u][ANG_W-1:0];
			aq[u] = neg[u] ? HALF_TURN - q[u] : q[u];
		end
		aok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			// checking each pair i, i+1 covers both neighbors of every corner
			s[i] = signed'({2'b00, ang_s1[i]}) + signed'({2'b00, ang_s1[(i+1)%4]})
				- signed'({2'b00, STRAIGHT});
			sa[i] = s[i][ANG_W+1] ? $unsigned(-s[i]) : $unsigned(s[i]);
			if (sa[i] > (ANG_W+2)'({acfg.corner_tol, 20'b0}))
				aok = 1'b0;
			if (ang_s1[i] > {acfg.max_corner, 20'b0} || ang_s1[i] < {acfg.min_corner, 20'b0})
				aok = 1'b0;
			cand[i] = (nz_s1[i] && ang_s1[4+i] < STRAIGHT) ? ang_s1[4+i] : STRAIGHT;
		end
		m01  = (cand[0] < cand[1]) ? cand[0] : cand[1];
		m23  = (cand[2] < cand[3]) ? cand[2] : cand[3];
		emin = (m01_s2 < m23_s2) ? m01_s2 : m23_s2;
		rnd  = {1'b0, emin} + HALF;
		shv  = rnd >> SH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int u = 0; u < 8; u++)
				ang_s1[u] <= aq[u];
			for (int i = 0; i < 4; i++)
				nz_s1[i] <= !zero[4+i];
			side_ok_s1 <= side_ok;
			ok_s2  <= aok && side_ok_s1;
			m01_s2 <= m01;
			m23_s2 <= m23;
			accepted       <= ok_s2;
			min_edge_angle <= ok_s2 ? shv[OUT_W-1:0] : '0;
		end
	end

endmodule
`default_nettype wire

// ===== design/quad_corner_block_check.sv =====
// Top level of the quadrilateral corner and side check pipeline.
// Uses qcb_pkg, qcb_quad_if, qcb_result_if, qcb_front, qcb_cordic_stage, qcb_check.
//
//  channel  | dir | beat payload
//  ---------+-----+--------------------------------------------------
//  quad     | in  | corner0_x .. corner3_y, COORD_BITS each
//  result   | out | accepted, min_edge_angle (14 bits)
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One quadrilateral per cycle unless result stalls; 4 front stages, one stage
// per step of the 24-step CORDIC (eight units side by side), 3 back stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on result freezes the whole pipeline; quad.ready follows it.
`default_nettype none
module quad_corner_block_check #(
	parameter int COORD_BITS      = qcb_pkg::COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = qcb_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	qcb_quad_if.sink                               quad,
	qcb_result_if.source                           result,
	input  wire logic                              cfg_we,
	input  wire logic [qcb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qcb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import qcb_pkg::*;

	localparam int W   = 2 * COORD_BITS + PRESCALE + 4;
	localparam int LAT = 4 + CORDIC_STEPS + 3;

	logic [6:0]  corner_tol_q;
	logic [7:0]  max_corner_q, min_corner_q;
	logic [4:0]  side_ratio_q;
	logic [10:0] min_side_q;
	logic [9:0]  r2_q;
	logic [21:0] ms2_q;
	logic [LAT-1:0] vld_q;
	logic           adv;

	logic [COORD_BITS-1:0]  px [4], py [4];
	logic signed [W-1:0]    cx [CORDIC_STEPS+1][8], cy [CORDIC_STEPS+1][8];
	logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1][8];
	logic                   cn [CORDIC_STEPS+1][8], c0 [CORDIC_STEPS+1][8];
	logic                   side_ok_s4;
	logic                   side_ok_sc [CORDIC_STEPS];
	angle_cfg_t             acfg;

	assign adv          = !vld_q[LAT-1] || result.ready;
	assign quad.ready   = adv;
	assign result.valid = vld_q[LAT-1];

	assign px = '{quad.corner0_x, quad.corner1_x, quad.corner2_x, quad.corner3_x};
	assign py = '{quad.corner0_y, quad.corner1_y, quad.corner2_y, quad.corner3_y};

	assign acfg = '{corner_tol: corner_tol_q, max_corner: max_corner_q,
		min_corner: min_corner_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_tol_q <= RST_CORNER_TOL;
			max_corner_q <= RST_MAX_CORNER;
			min_corner_q <= RST_MIN_CORNER;
			side_ratio_q <= RST_SIDE_RATIO;
			min_side_q   <= RST_MIN_SIDE;
			vld_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CORNER_TOL: corner_tol_q <= cfg_data[6:0];
					CFG_MAX_CORNER: max_corner_q <= cfg_data[7:0];
					CFG_MIN_CORNER: min_corner_q <= cfg_data[7:0];
					CFG_SIDE_RATIO: side_ratio_q <= cfg_data[4:0];
					CFG_MIN_SIDE:   min_side_q   <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (adv)
				vld_q <= {vld_q[LAT-2:0], quad.valid};
		end
	end

	// squared limits settle well before an item reaches the side check
	always_ff @(posedge clk) begin
		r2_q  <= side_ratio_q * side_ratio_q;
		ms2_q <= min_side_q * min_side_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_ok_sc[0] <= side_ok_s4;
			for (int k = 1; k < CORDIC_STEPS; k++)
				side_ok_sc[k] <= side_ok_sc[k-1];
		end
	end

	qcb_front #(.COORD_BITS(COORD_BITS), .PRESCALE_W(PRESCALE + 4)) u_front (
		.clk(clk), .adv(adv), .px(px), .py(py), .r2(r2_q), .ms2(ms2_q),
		.x0(cx[0]), .y0(cy[0]), .neg0(cn[0]), .zero0(c0[0]), .side_ok(side_ok_s4)
	);

	for (genvar u = 0; u < 8; u++) begin : g_unit
		assign cz[0][u] = '0;
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
			qcb_cordic_stage #(.W(W), .K(k)) u_stage (
				.clk(clk), .adv(adv),
				.x_in(cx[k][u]), .y_in(cy[k][u]), .z_in(cz[k][u]),
				.neg_in(cn[k][u]), .zero_in(c0[k][u]),
				.x_out(cx[k+1][u]), .y_out(cy[k+1][u]), .z_out(cz[k+1][u]),
				.neg_out(cn[k+1][u]), .zero_out(c0[k+1][u])
			);
		end
	end

	qcb_check #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_check (
		.clk(clk), .adv(adv),
		.z(cz[CORDIC_STEPS]), .neg(cn[CORDIC_STEPS]), .zero(c0[CORDIC_STEPS]),
		.side_ok(side_ok_sc[CORDIC_STEPS-1]), .acfg(acfg),
		.accepted(result.accepted), .min_edge_angle(result.min_edge_angle)
	);

endmodule
`default_nettype wire
